// ===== hdl/ps2hfe_pkg.sv =====
// shared types and constants of the ps2 host frame engine
`default_nettype none
package ps2hfe_pkg;

	localparam int unsigned DataBits  = 8;
	localparam int unsigned MaxPacket = 4;

	localparam logic [3:0] LAST_EDGE    = 4'd10;
	localparam logic [3:0] RELEASE_EDGE = 4'd9;
	localparam logic [3:0] DATA_EDGE    = 4'd8;
	localparam logic [2:0] LEN_RESET    = 3'd3;
	localparam logic [2:0] LEN_MAX      = 3'd4;

	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_SEND = 1'b1;

	typedef logic [DataBits-1:0] byte_t;

	typedef struct packed {
		logic  command;
		logic  data_in;
		byte_t tx_byte;
	} item_t;

	typedef struct packed {
		logic  drive_enable;
		logic  drive_level;
		logic  transmitting;
		logic  byte_done;
		byte_t byte_value;
		logic  packet_done;
		byte_t packet_first;
		byte_t packet_second;
		byte_t packet_third;
		byte_t packet_fourth;
	} result_t;

	// clamp the packet length register to 1..4
	function automatic logic [2:0] eff_length(input logic [2:0] len);
		logic [2:0] r;
		r = len;
		if (len == 3'd0) r = 3'd1;
		if (len > LEN_MAX) r = LEN_MAX;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/ps2_host_frame_engine_unit.sv =====
// top level of the ps2 host frame engine
//
// channel   direction  handshake                 payload
// input     in         in_valid / in_stall       command, data_in, tx_byte
// output    out        out_valid / out_stall     drive and receive results
// config    in         cfg_wr_en                 cfg_wr_data (packet length)
//
// each transaction passes through the input register and then the
// result register; one item per cycle is sustained while out_stall is low, set by the single
// state update in the frame core. reset clears frame state, packet store and
// sets packet length to three. while the result waits under out_stall one more
// item is held in the input register, then in_stall rises.
`default_nettype none
module ps2_host_frame_engine_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [2:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       command,
	input  wire logic       data_in,
	input  wire logic [7:0] tx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            drive_enable,
	output logic            drive_level,
	output logic            transmitting,
	output logic            byte_done,
	output logic [7:0]      byte_value,
	output logic            packet_done,
	output logic [7:0]      packet_first,
	output logic [7:0]      packet_second,
	output logic [7:0]      packet_third,
	output logic [7:0]      packet_fourth
);
	import ps2hfe_pkg::*;

	item_t      item;
	item_t      item_s1;
	logic       valid_s1;
	logic       advance;
	logic [2:0] packet_length;
	result_t    result_q;

	assign item.command = command;
	assign item.data_in = data_in;
	assign item.tx_byte = tx_byte;

	ps2hfe_cfg_reg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.packet_length_q (packet_length)
	);

	ps2hfe_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ps2hfe_frame_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.packet_length (packet_length),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_q      (result_q)
	);

	assign drive_enable  = result_q.drive_enable;
	assign drive_level   = result_q.drive_level;
	assign transmitting  = result_q.transmitting;
	assign byte_done     = result_q.byte_done;
	assign byte_value    = result_q.byte_value;
	assign packet_done   = result_q.packet_done;
	assign packet_first  = result_q.packet_first;
	assign packet_second = result_q.packet_second;
	assign packet_third  = result_q.packet_third;
	assign packet_fourth = result_q.packet_fourth;

endmodule
`default_nettype wire

// ===== hdl/ps2hfe_in_stage.sv =====
// input register stage of the ps2 host frame engine
`default_nettype none
module ps2hfe_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire ps2hfe_pkg::item_t item,
	input  wire logic            advance,
	output logic                 valid_s1,
	output ps2hfe_pkg::item_t    item_s1
);
	import ps2hfe_pkg::*;

	logic load;

	assign in_stall = valid_s1 & ~advance;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ps2hfe_frame_core.sv =====
// frame state, next-state logic and result register of the ps2 host frame engine
`default_nettype none
module ps2hfe_frame_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [2:0]        packet_length,
	input  wire logic              valid_s1,
	input  wire ps2hfe_pkg::item_t item_s1,
	output logic                   advance,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output ps2hfe_pkg::result_t    result_q
);
	import ps2hfe_pkg::*;

	logic       host_sending_q;
	logic [3:0] edge_count_q;
	byte_t      send_shift_q;
	logic [1:0] byte_index_q;
	byte_t      store_q [MaxPacket];

	logic       host_sending_n;
	logic [3:0] edge_count_n;
	byte_t      send_shift_n;
	logic [1:0] byte_index_n;
	byte_t      store_n [MaxPacket];
	result_t    res_n;
	logic       take;
	logic [2:0] edge_m1;
	logic [2:0] edge_n_m1;
	byte_t      cur_byte;
	logic [2:0] len;

	assign advance = ~out_valid | ~out_stall;
	assign take    = valid_s1 & advance;
	assign len     = eff_length(packet_length);
	assign edge_m1   = edge_count_q[2:0] - 3'd1;
	assign edge_n_m1 = edge_count_n[2:0] - 3'd1;

	always_comb begin
		host_sending_n = host_sending_q;
		edge_count_n   = edge_count_q;
		send_shift_n   = send_shift_q;
		byte_index_n   = byte_index_q;
		for (int i = 0; i < MaxPacket; i++) store_n[i] = store_q[i];
		cur_byte       = store_q[byte_index_q];
		res_n          = '0;

		if (item_s1.command == CMD_SEND) begin
			host_sending_n = 1'b1;
			send_shift_n   = item_s1.tx_byte;
			byte_index_n   = 2'd0;
			edge_count_n   = 4'd0;
		end else if (host_sending_q) begin
			if (edge_count_q >= LAST_EDGE) begin
				edge_count_n   = 4'd0;
				host_sending_n = 1'b0;
			end else begin
				edge_count_n = edge_count_q + 4'd1;
			end
		end else begin
			// start bit clears the byte, data bits fill lsb first
			if (edge_count_q == 4'd0) begin
				cur_byte = '0;
			end else if (edge_count_q <= DATA_EDGE) begin
				cur_byte[edge_m1] = cur_byte[edge_m1] | item_s1.data_in;
			end
			store_n[byte_index_q] = cur_byte;
			if (edge_count_q >= LAST_EDGE) begin
				edge_count_n     = 4'd0;
				res_n.byte_done  = 1'b1;
				res_n.byte_value = cur_byte;
				if ({1'b0, byte_index_q} + 3'd1 >= len) begin
					byte_index_n      = 2'd0;
					res_n.packet_done = 1'b1;
				end else begin
					byte_index_n = byte_index_q + 2'd1;
				end
			end else begin
				edge_count_n = edge_count_q + 4'd1;
			end
		end

		res_n.transmitting = host_sending_n;
		if (host_sending_n && edge_count_n <= RELEASE_EDGE) begin
			res_n.drive_enable = 1'b1;
			if (edge_count_n == 4'd0) begin
				res_n.drive_level = 1'b0;
			end else if (edge_count_n <= DATA_EDGE) begin
				res_n.drive_level = send_shift_n[edge_n_m1];
			end else begin
				res_n.drive_level = ~(^send_shift_n);
			end
		end

		if (res_n.packet_done) begin
			res_n.packet_first  = store_n[0];
			res_n.packet_second = store_n[1];
			res_n.packet_third  = store_n[2];
			res_n.packet_fourth = store_n[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_sending_q <= 1'b0;
			edge_count_q   <= 4'd0;
			send_shift_q   <= '0;
			byte_index_q   <= 2'd0;
			for (int i = 0; i < MaxPacket; i++) store_q[i] <= '0;
		end else if (take) begin
			host_sending_q <= host_sending_n;
			edge_count_q   <= edge_count_n;
			send_shift_q   <= send_shift_n;
			byte_index_q   <= byte_index_n;
			for (int i = 0; i < MaxPacket; i++) store_q[i] <= store_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= res_n;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ps2hfe_cfg_reg.sv =====
// packet length register of the ps2 host frame engine
`default_nettype none
module ps2hfe_cfg_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [2:0] cfg_wr_data,
	output logic [2:0]      packet_length_q
);
	import ps2hfe_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_length_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			packet_length_q <= cfg_wr_data;
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/ps2_host_frame_engine_unit_tb.sv =====
// testbench of the ps2 host frame engine: receive and transmit frames checked against a predictor
module ps2_host_frame_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ps2hfe_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [2:0] cfg_wr_data = 3'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       command = CMD_EDGE;
	logic       data_in = 1'b0;
	byte_t      tx_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       drive_enable;
	logic       drive_level;
	logic       transmitting;
	logic       byte_done;
	byte_t      byte_value;
	logic       packet_done;
	byte_t      packet_first;
	byte_t      packet_second;
	byte_t      packet_third;
	byte_t      packet_fourth;

	ps2_host_frame_engine_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.data_in      (data_in),
		.tx_byte      (tx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive_enable (drive_enable),
		.drive_level  (drive_level),
		.transmitting (transmitting),
		.byte_done    (byte_done),
		.byte_value   (byte_value),
		.packet_done  (packet_done),
		.packet_first (packet_first),
		.packet_second(packet_second),
		.packet_third (packet_third),
		.packet_fourth(packet_fourth)
	);

	// frame state mirrored by the predictor
	logic [2:0] rx_len_cfg = LEN_RESET;
	logic       host_tx = 1'b0;
	logic [3:0] frame_edge = '0;
	byte_t      tx_hold = '0;
	logic [1:0] pkt_slot = '0;
	byte_t      pkt_bytes [MaxPacket] = '{default: '0};

	result_t expected_results [$];
	int      mismatches = 0;
	int      items_sent = 0;
	int      snd_idle_pct = 38;
	int      rcv_idle_pct = 81;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	function automatic result_t frame_response(input item_t it);
		result_t    r;
		logic [1:0] slot;
		logic [2:0] span;
		r = '0;
		if (it.command == CMD_SEND) begin
			host_tx = 1'b1;
			tx_hold = it.tx_byte;
			pkt_slot = '0;
			frame_edge = '0;
		end else if (host_tx) begin
			if (frame_edge >= LAST_EDGE) begin
				frame_edge = '0;
				host_tx = 1'b0;
			end else begin
				frame_edge = frame_edge + 4'd1;
			end
		end else begin
			slot = pkt_slot;
			if (frame_edge == 4'd0)
				pkt_bytes[slot] = '0;
			else if (frame_edge <= DATA_EDGE)
				pkt_bytes[slot][3'(frame_edge - 4'd1)] =
					pkt_bytes[slot][3'(frame_edge - 4'd1)] | it.data_in;
			if (frame_edge >= LAST_EDGE) begin
				frame_edge = '0;
				r.byte_done = 1'b1;
				r.byte_value = pkt_bytes[slot];
				// zero counts as one, anything past four as four
				span = (rx_len_cfg == 3'd0) ? 3'd1 :
					((rx_len_cfg > LEN_MAX) ? LEN_MAX : rx_len_cfg);
				if ({1'b0, slot} + 3'd1 >= span) begin
					pkt_slot = '0;
					r.packet_done = 1'b1;
				end else begin
					pkt_slot = slot + 2'd1;
				end
			end else begin
				frame_edge = frame_edge + 4'd1;
			end
		end
		if (host_tx && frame_edge <= RELEASE_EDGE) begin
			r.drive_enable = 1'b1;
			if (frame_edge == 4'd0)
				r.drive_level = 1'b0;
			else if (frame_edge <= DATA_EDGE)
				r.drive_level = tx_hold[3'(frame_edge - 4'd1)];
			else
				r.drive_level = ~^tx_hold;
		end
		r.transmitting = host_tx;
		if (r.packet_done) begin
			r.packet_first = pkt_bytes[0];
			r.packet_second = pkt_bytes[1];
			r.packet_third = pkt_bytes[2];
			r.packet_fourth = pkt_bytes[3];
		end
		return r;
	endfunction

	function automatic string describe_result(input result_t r);
		return $sformatf("en %b lvl %b tx %b bd %b bv %h pd %b pkt %h %h %h %h",
			r.drive_enable, r.drive_level, r.transmitting, r.byte_done, r.byte_value,
			r.packet_done, r.packet_first, r.packet_second, r.packet_third,
			r.packet_fourth);
	endfunction

	always @(posedge clk) begin : result_check
		result_t seen;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {drive_enable, drive_level, transmitting, byte_done, byte_value,
				packet_done, packet_first, packet_second, packet_third, packet_fourth};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: %s", describe_result(seen));
			end else begin
				want = expected_results.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t\n  expected %s\n  actual   %s", $realtime,
							describe_result(want), describe_result(seen));
				end
			end
		end
	end

	task automatic send_item(input item_t it);
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
		end
		in_valid <= 1'b1;
		command <= it.command;
		data_in <= it.data_in;
		tx_byte <= it.tx_byte;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(frame_response(it));
		items_sent++;
	endtask

	task automatic send_edge(input logic level);
		item_t it;
		it.command = CMD_EDGE;
		it.data_in = level;
		it.tx_byte = byte_t'($urandom);
		send_item(it);
	endtask

	task automatic rx_frame(input byte_t b);
		send_edge(1'b0);
		for (int k = 0; k < DataBits; k++)
			send_edge(b[k]);
		send_edge(~^b);
		send_edge(1'b1);
	endtask

	task automatic tx_frame(input byte_t b);
		item_t it;
		it.command = CMD_SEND;
		it.data_in = 1'($urandom);
		it.tx_byte = b;
		send_item(it);
		repeat (LAST_EDGE + 1)
			send_edge(1'($urandom));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(input logic [2:0] len);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		rx_len_cfg = len;
		cfg_wr_en <= 1'b0;
	endtask

	// shorten the packet while one byte is already stored
	task automatic test_index_past_length;
		rx_frame(8'hFF);
		drain();
		write_length(3'd1);
		rx_frame(8'h00);
		drain();
	endtask

	// full transmit frames of both extreme bytes, one cutting into a receive frame
	task automatic test_directed_frames;
		tx_frame(8'hFF);
		repeat (3) send_edge(1'b1);
		tx_frame(8'h00);
		drain();
	endtask

	task automatic run_mixed(input int count);
		int    stop_at;
		int    pick;
		item_t it;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				rx_frame(byte_t'($urandom));
			end else if (pick < 80) begin
				tx_frame(byte_t'($urandom));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 10))
					send_edge(1'($urandom));
			end else begin
				it.command = ($urandom_range(3) == 0) ? CMD_SEND : CMD_EDGE;
				it.data_in = 1'($urandom);
				it.tx_byte = byte_t'($urandom);
				send_item(it);
			end
		end
	endtask

	task automatic test_random_traffic;
		logic [2:0] lengths [9];
		lengths = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd6, 3'd4, 3'd3};
		for (int p = 0; p < 9; p++) begin
			if (p == 3) begin
				snd_idle_pct = 81;
				rcv_idle_pct = 38;
			end else if (p == 6) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			write_length(lengths[p]);
			run_mixed(100);
			drain();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_index_past_length();
		test_directed_frames();
		test_random_traffic();
		drain();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
